### design/hist_eq_pkg.sv
// ----------------------------------------------------------------------------
// hist_eq_pkg
// Shared types and constants of the histogram equalizer: widths of the
// counters, the cumulative sum and the fixed-point divide, and action codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hist_eq_pkg;

	localparam int COUNT_BITS = 20;
	localparam int PIX_W      = 8;
	localparam int LEVELS     = 256;
	localparam int LEVEL_W    = 16;

	// 255.0 in unsigned 8.8
	localparam logic [LEVEL_W-1:0] LEVEL_SCALE = 16'd65280;

	// cumulative count over all bins, and cum * 255 * 256
	localparam int CUM_W     = COUNT_BITS + PIX_W;
	localparam int PROD_W    = CUM_W + LEVEL_W;
	// quotient bits kept by the divider: one above the level width
	localparam int QUOT_BITS = LEVEL_W + 1;
	localparam int STEP_W    = $clog2(QUOT_BITS);

	typedef enum logic [1:0] {
		ACT_COUNT  = 2'd0,
		ACT_FINISH = 2'd1,
		ACT_MAP    = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

endpackage

`default_nettype wire

### design/hist_eq_ram.sv
// ----------------------------------------------------------------------------
// hist_eq_ram
// Simple dual-port synchronous RAM, one write and one read port, read data
// registered (old data on a same-address write).
// ----------------------------------------------------------------------------
`default_nettype none

module hist_eq_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### design/histogram_equalizer_top.sv
// ----------------------------------------------------------------------------
// histogram_equalizer_top
// 8-bit gray-level histogram equalizer. Items on the input channel count a
// pixel, build the equalization mapping, map a pixel or clear the histogram.
// Only map items give a result: the equalized level in unsigned 8.8 and a
// flag that no pixels were counted.
//
// Both channels use valid/stall; a transfer happens on a clock edge with
// valid high and stall low. Count and map items are taken one per cycle
// unless a walk, the reset pass or a held map result stalls the input; a
// bin update is a read-modify-write on the histogram RAM with forwarding
// of the previous write. A map result passes through stage 1 into the
// output register and holds there while out_stall is high; a following
// map then waits in stage 1 and the input stalls. A finish item walks all
// 256 bins: per bin a RAM read, accumulate, scale, a range check and a
// 17-step restoring divide by the pixel total (skipped when the total is
// zero or the quotient would not fit), then a mapping RAM write. A clear
// item walks the 256 histogram bins and zeroes them. After reset a clearing
// pass zeroes both RAMs; the input stalls until it is done.
// ----------------------------------------------------------------------------
`default_nettype none

module histogram_equalizer_top
	import hist_eq_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [1:0]         action,
	input  wire logic [PIX_W-1:0]   pixel,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [LEVEL_W-1:0]      level_q8,
	output logic                    empty_frame
);

	typedef enum logic [3:0] {
		ST_INIT,
		ST_RUN,
		ST_CLEAR,
		ST_FIN_RD,
		ST_FIN_ACC,
		ST_FIN_MUL,
		ST_FIN_CHK,
		ST_FIN_DIV,
		ST_FIN_WR
	} state_t;

	state_t                  state_q;
	logic [PIX_W-1:0]        idx_q;
	logic [COUNT_BITS-1:0]   total_q;

	// stage 1: item whose RAM read was issued at transfer
	logic                    valid_s1;
	action_t                 action_s1;
	logic [PIX_W-1:0]        pixel_s1;
	logic                    empty_s1;

	// last histogram write, for back-to-back counts of one bin
	logic                    fwd_valid_q;
	logic [PIX_W-1:0]        fwd_addr_q;
	logic [COUNT_BITS-1:0]   fwd_data_q;

	// mapping build
	logic [CUM_W-1:0]        cum_q;
	logic [PROD_W-1:0]       prod_q;
	logic [COUNT_BITS-1:0]   rem_q;
	logic [QUOT_BITS-1:0]    dvd_q;
	logic [QUOT_BITS-1:0]    quo_q;
	logic [STEP_W-1:0]       step_q;

	logic                    out_valid_q;
	logic [LEVEL_W-1:0]      level_q;
	logic                    empty_q;

	logic                    bin_we;
	logic [PIX_W-1:0]        bin_waddr;
	logic [COUNT_BITS-1:0]   bin_wdata;
	logic [PIX_W-1:0]        bin_raddr;
	logic [COUNT_BITS-1:0]   bin_rdata;

	logic                    map_we;
	logic [LEVEL_W-1:0]      map_wdata;
	logic [PIX_W-1:0]        map_raddr;
	logic [LEVEL_W-1:0]      map_rdata;

	logic                    s1_hold;
	logic                    s1_walk;
	logic                    s1_count;
	logic                    accept;
	logic [COUNT_BITS-1:0]   bin_old;
	logic [COUNT_BITS-1:0]   bin_new;
	logic [COUNT_BITS:0]     trial;
	logic [COUNT_BITS:0]     diff;
	logic                    trial_ge;
	logic [LEVEL_W-1:0]      level_clamped;
	logic                    idx_last;

	hist_eq_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (LEVELS)
	) u_bin_ram (
		.clk   (clk),
		.we    (bin_we),
		.waddr (bin_waddr),
		.wdata (bin_wdata),
		.raddr (bin_raddr),
		.rdata (bin_rdata)
	);

	hist_eq_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (LEVELS)
	) u_map_ram (
		.clk   (clk),
		.we    (map_we),
		.waddr (idx_q),
		.wdata (map_wdata),
		.raddr (map_raddr),
		.rdata (map_rdata)
	);

	always_comb begin
		s1_hold  = valid_s1 && (action_s1 == ACT_MAP) && out_valid_q && out_stall;
		s1_walk  = valid_s1 && (action_s1 == ACT_FINISH || action_s1 == ACT_CLEAR);
		s1_count = valid_s1 && (action_s1 == ACT_COUNT);
		in_stall = (state_q != ST_RUN) || s1_hold || s1_walk;
		accept   = in_valid && !in_stall;
		idx_last = (idx_q == PIX_W'(LEVELS - 1));

		bin_old = (fwd_valid_q && fwd_addr_q == pixel_s1) ? fwd_data_q : bin_rdata;
		bin_new = (bin_old == {COUNT_BITS{1'b1}}) ? bin_old : bin_old + 1'b1;

		bin_we    = 1'b0;
		bin_waddr = idx_q;
		bin_wdata = '0;
		if (state_q == ST_INIT || state_q == ST_CLEAR) begin
			bin_we = 1'b1;
		end else if (state_q == ST_RUN && s1_count) begin
			bin_we    = 1'b1;
			bin_waddr = pixel_s1;
			bin_wdata = bin_new;
		end
		bin_raddr = (state_q == ST_RUN) ? pixel : idx_q;

		trial    = {rem_q, dvd_q[QUOT_BITS-1]};
		trial_ge = (trial >= {1'b0, total_q});
		diff     = trial - {1'b0, total_q};

		level_clamped = (quo_q > QUOT_BITS'(LEVEL_SCALE)) ? LEVEL_SCALE
			: quo_q[LEVEL_W-1:0];

		map_we    = (state_q == ST_INIT) || (state_q == ST_FIN_WR);
		map_wdata = (state_q == ST_FIN_WR) ? level_clamped : '0;
		map_raddr = s1_hold ? pixel_s1 : pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			idx_q       <= '0;
			total_q     <= '0;
			valid_s1    <= 1'b0;
			fwd_valid_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			fwd_valid_q <= 1'b0;

			// output register
			if (valid_s1 && action_s1 == ACT_MAP && !s1_hold) begin
				out_valid_q <= 1'b1;
				level_q     <= map_rdata;
				empty_q     <= empty_s1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			// stage 1
			if (!s1_hold) begin
				valid_s1 <= accept;
				if (accept) begin
					action_s1 <= action_t'(action);
					pixel_s1  <= pixel;
					empty_s1  <= (total_q == '0);
				end
			end

			if (accept && action_t'(action) == ACT_COUNT
				&& total_q != {COUNT_BITS{1'b1}}) begin
				total_q <= total_q + 1'b1;
			end

			case (state_q)
				ST_INIT: begin
					idx_q <= idx_q + 1'b1;
					if (idx_last) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (s1_count) begin
						fwd_valid_q <= 1'b1;
						fwd_addr_q  <= pixel_s1;
						fwd_data_q  <= bin_new;
					end
					if (s1_walk) begin
						idx_q <= '0;
						cum_q <= '0;
						if (action_s1 == ACT_CLEAR) begin
							total_q <= '0;
							state_q <= ST_CLEAR;
						end else begin
							state_q <= ST_FIN_RD;
						end
					end
				end
				ST_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_last) begin
						state_q <= ST_RUN;
					end
				end
				ST_FIN_RD: begin
					state_q <= ST_FIN_ACC;
				end
				ST_FIN_ACC: begin
					cum_q   <= cum_q + CUM_W'(bin_rdata);
					state_q <= ST_FIN_MUL;
				end
				ST_FIN_MUL: begin
					// cum * 65280 = cum * 2^16 - cum * 2^8
					prod_q  <= {cum_q, {LEVEL_W{1'b0}}} - {{PIX_W{1'b0}}, cum_q, {PIX_W{1'b0}}};
					state_q <= ST_FIN_CHK;
				end
				ST_FIN_CHK: begin
					if (total_q == '0) begin
						quo_q   <= '0;
						state_q <= ST_FIN_WR;
					end else if (prod_q >= PROD_W'({total_q, {QUOT_BITS{1'b0}}})) begin
						quo_q   <= QUOT_BITS'(LEVEL_SCALE);
						state_q <= ST_FIN_WR;
					end else begin
						// high part is below the total, so it fits the remainder
						rem_q   <= COUNT_BITS'(prod_q >> QUOT_BITS);
						dvd_q   <= prod_q[QUOT_BITS-1:0];
						quo_q   <= '0;
						step_q  <= '0;
						state_q <= ST_FIN_DIV;
					end
				end
				ST_FIN_DIV: begin
					rem_q  <= trial_ge ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
					quo_q  <= {quo_q[QUOT_BITS-2:0], trial_ge};
					dvd_q  <= {dvd_q[QUOT_BITS-2:0], 1'b0};
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(QUOT_BITS - 1)) begin
						state_q <= ST_FIN_WR;
					end
				end
				ST_FIN_WR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_last) begin
						state_q <= ST_RUN;
					end else begin
						state_q <= ST_FIN_RD;
					end
				end
				default: begin
					state_q <= ST_INIT;
					idx_q   <= '0;
				end
			endcase
		end
	end

	assign out_valid   = out_valid_q;
	assign level_q8    = level_q;
	assign empty_frame = empty_q;

endmodule

`default_nettype wire
